// ===== src/cnq_pkg.sv =====
// Shared types and constants for the cylinder nearest-object query block.
// No dependencies; imported by every module of the block except cnq_fifo.
package cnq_pkg;

    // Configuration register index width and register map
    localparam int CFG_IDX_BITS = 3;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_ORIGIN_X      = 3'd0,
        REG_ORIGIN_Y      = 3'd1,
        REG_ORIGIN_Z      = 3'd2,
        REG_SEARCH_RADIUS = 3'd3,
        REG_BAND_BOTTOM   = 3'd4,
        REG_BAND_HEIGHT   = 3'd5,
        REG_WANTED_CLASS  = 3'd6
    } cnq_reg_idx_t;

    // Depth of the queue between classification and distance evaluation
    localparam int QUEUE_DEPTH = 4;

    // Classification result carried with each candidate through the queue
    typedef struct packed {
        logic cand_ok;   // passes filters and lies strictly inside the y band
        logic last;      // final candidate of the query
    } cnq_flags_t;

endpackage

// ===== src/cnq_cfg.sv =====
// Configuration register file with derived band limits and radius square.
// Depends on cnq_pkg.
module cnq_cfg #(
    parameter int COORD_BITS = 24,
    parameter int CLASS_BITS = 4
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_we,
    input  logic [cnq_pkg::CFG_IDX_BITS-1:0]    cfg_idx,
    input  logic [COORD_BITS-1:0]               cfg_wdata,
    output logic signed [COORD_BITS-1:0]        origin_x,
    output logic signed [COORD_BITS-1:0]        origin_y,
    output logic signed [COORD_BITS-1:0]        origin_z,
    output logic [CLASS_BITS-1:0]               wanted_class,
    output logic signed [COORD_BITS:0]          band_lo,
    output logic signed [COORD_BITS:0]          band_hi,
    output logic [2*COORD_BITS-3:0]             radius_sq
);
    import cnq_pkg::*;

    localparam int C = COORD_BITS;

    logic signed [C-1:0]   origin_x_reg;
    logic signed [C-1:0]   origin_y_reg;
    logic signed [C-1:0]   origin_z_reg;
    logic [C-2:0]          radius_reg;
    logic signed [C-1:0]   bottom_reg;
    logic signed [C-1:0]   height_reg;
    logic [CLASS_BITS-1:0] class_reg;

    logic signed [C:0]     band_lo_reg;
    logic signed [C:0]     band_hi_reg;
    logic [2*C-3:0]        radius_sq_reg;

    // Register writes; an index beyond the map is dropped
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            origin_x_reg <= '0;
            origin_y_reg <= '0;
            origin_z_reg <= '0;
            radius_reg   <= '0;
            bottom_reg   <= '0;
            height_reg   <= '0;
            class_reg    <= '0;
        end else if (cfg_we) begin
            unique case (cnq_reg_idx_t'(cfg_idx))
                REG_ORIGIN_X:      origin_x_reg <= cfg_wdata;
                REG_ORIGIN_Y:      origin_y_reg <= cfg_wdata;
                REG_ORIGIN_Z:      origin_z_reg <= cfg_wdata;
                REG_SEARCH_RADIUS: radius_reg   <= cfg_wdata[C-2:0];
                REG_BAND_BOTTOM:   bottom_reg   <= cfg_wdata;
                REG_BAND_HEIGHT:   height_reg   <= cfg_wdata;
                REG_WANTED_CLASS:  class_reg    <= cfg_wdata[CLASS_BITS-1:0];
                default: ;
            endcase
        end
    end

    // Register the absolute band limits and the radius square from the stored configuration
    always_ff @(posedge aclk) begin
        band_lo_reg   <= $signed({origin_y_reg[C-1], origin_y_reg})
                       + $signed({bottom_reg[C-1], bottom_reg});
        band_hi_reg   <= $signed({origin_y_reg[C-1], origin_y_reg})
                       + $signed({height_reg[C-1], height_reg});
        radius_sq_reg <= (2*C-2)'(radius_reg) * (2*C-2)'(radius_reg);
    end

    assign origin_x     = origin_x_reg;
    assign origin_y     = origin_y_reg;
    assign origin_z     = origin_z_reg;
    assign wanted_class = class_reg;
    assign band_lo      = band_lo_reg;
    assign band_hi      = band_hi_reg;
    assign radius_sq    = radius_sq_reg;

endmodule

// ===== src/cnq_front.sv =====
// Front end: target point, filters, y band test and origin differences.
// Depends on cnq_pkg.
module cnq_front #(
    parameter int COORD_BITS = 24,
    parameter int CLASS_BITS = 4
) (
    input  logic signed [COORD_BITS-1:0]   obj_x,
    input  logic signed [COORD_BITS-1:0]   obj_y,
    input  logic signed [COORD_BITS-1:0]   obj_z,
    input  logic signed [COORD_BITS-1:0]   off_x,
    input  logic signed [COORD_BITS-1:0]   off_y,
    input  logic signed [COORD_BITS-1:0]   off_z,
    input  logic                           has_hitbox,
    input  logic                           is_self,
    input  logic [CLASS_BITS-1:0]          object_class,
    input  logic                           last_entry,
    input  logic signed [COORD_BITS-1:0]   origin_x,
    input  logic signed [COORD_BITS-1:0]   origin_y,
    input  logic signed [COORD_BITS-1:0]   origin_z,
    input  logic [CLASS_BITS-1:0]          wanted_class,
    input  logic signed [COORD_BITS:0]     band_lo,
    input  logic signed [COORD_BITS:0]     band_hi,
    output logic signed [COORD_BITS+1:0]   diff_x,
    output logic signed [COORD_BITS+1:0]   diff_y,
    output logic signed [COORD_BITS+1:0]   diff_z,
    output cnq_pkg::cnq_flags_t            flags
);
    import cnq_pkg::*;

    localparam int C = COORD_BITS;

    logic signed [C:0] tgt_x;
    logic signed [C:0] tgt_y;
    logic signed [C:0] tgt_z;
    logic              filter_ok;
    logic              in_band;

    // Target point: position plus hitbox offset
    assign tgt_x = $signed({obj_x[C-1], obj_x}) + $signed({off_x[C-1], off_x});
    assign tgt_y = $signed({obj_y[C-1], obj_y}) + $signed({off_y[C-1], off_y});
    assign tgt_z = $signed({obj_z[C-1], obj_z}) + $signed({off_z[C-1], off_z});

    // Offsets from the query origin
    assign diff_x = $signed({tgt_x[C], tgt_x}) - $signed({{2{origin_x[C-1]}}, origin_x});
    assign diff_y = $signed({tgt_y[C], tgt_y}) - $signed({{2{origin_y[C-1]}}, origin_y});
    assign diff_z = $signed({tgt_z[C], tgt_z}) - $signed({{2{origin_z[C-1]}}, origin_z});

    // Classify: filters and open y band
    assign filter_ok = !is_self && has_hitbox && (object_class == wanted_class);
    assign in_band   = (band_lo < tgt_y) && (band_hi > tgt_y);

    assign flags.cand_ok = filter_ok && in_band;
    assign flags.last    = last_entry;

endmodule

// ===== src/cnq_fifo.sv =====
// Small register queue between the front end and the distance back end.
// Standalone; DEPTH must be a power of two.
module cnq_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             wr_en,
    input  logic [WIDTH-1:0] wr_data,
    output logic             full,
    input  logic             rd_en,
    output logic [WIDTH-1:0] rd_data,
    output logic             not_empty
);
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg;
    logic [PW-1:0]    rd_ptr_reg;
    logic [CW-1:0]    count_reg;
    logic [CW-1:0]    count_next;

    assign full      = (count_reg == CW'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign rd_data   = mem_reg[rd_ptr_reg];

    always_comb begin
        count_next = count_reg;
        if (wr_en && !rd_en) begin
            count_next = count_reg + 1'b1;
        end else if (rd_en && !wr_en) begin
            count_next = count_reg - 1'b1;
        end
    end

    // Advance pointers and the fill count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (wr_en) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (rd_en) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    // Store the entry
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(DEPTH))
        else $error("queue fill count exceeds depth");

    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        rd_en |-> count_reg != '0)
        else $error("queue read while empty");

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        wr_en && full |-> rd_en)
        else $error("queue written while full");
`endif

endmodule

// ===== src/cnq_back.sv =====
// Back end: squares, radius test, nearest tracking and the result register.
// Depends on cnq_pkg.
module cnq_back #(
    parameter int ID_BITS    = 10,
    parameter int COORD_BITS = 24
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [ID_BITS-1:0]            in_id,
    input  logic signed [COORD_BITS+1:0]  in_diff_x,
    input  logic signed [COORD_BITS+1:0]  in_diff_y,
    input  logic signed [COORD_BITS+1:0]  in_diff_z,
    input  cnq_pkg::cnq_flags_t           in_flags,
    input  logic [2*COORD_BITS-3:0]       radius_sq,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [ID_BITS-1:0]            m_echo_id,
    output logic                          m_is_match,
    output logic                          m_nearest_found,
    output logic [ID_BITS-1:0]            m_nearest_id,
    output logic                          m_query_done
);
    import cnq_pkg::*;

    localparam int C     = COORD_BITS;
    localparam int MAG_W = C + 1;
    localparam int MUL_W = (MAG_W > 31) ? 31 : MAG_W;
    localparam int SQ_W  = (MAG_W > 31) ? 63 : 2 * MAG_W;
    localparam int D_W   = SQ_W + 2;

    // Square of a magnitude, saturated to 2^62 at 2^31 and above
    function automatic logic [SQ_W-1:0] sat_square(input logic [MAG_W-1:0] mag);
        logic [MUL_W-1:0]   m;
        logic [2*MUL_W-1:0] p;
        m = mag[MUL_W-1:0];
        p = m * m;
        if ((mag >> MUL_W) != '0) begin
            sat_square = SQ_W'(1) << (SQ_W - 1);
        end else begin
            sat_square = SQ_W'(p);
        end
    endfunction

    function automatic logic [MAG_W-1:0] magnitude(input logic signed [C+1:0] d);
        logic [C+1:0] a;
        a = d[C+1] ? (C+2)'(-d) : d;
        magnitude = a[MAG_W-1:0];
    endfunction

    logic               out_free;
    logic               s1_adv;

    logic               s1_valid_reg;
    logic [ID_BITS-1:0] s1_id_reg;
    logic [SQ_W-1:0]    s1_sqx_reg;
    logic [SQ_W-1:0]    s1_sqy_reg;
    logic [SQ_W-1:0]    s1_sqz_reg;
    cnq_flags_t         s1_flags_reg;

    logic [D_W-1:0]     best_d_reg;
    logic [D_W-1:0]     best_d_next;
    logic [ID_BITS-1:0] best_id_reg;
    logic [ID_BITS-1:0] best_id_next;
    logic               best_valid_reg;
    logic               best_valid_next;

    logic               m_valid_reg;
    logic [ID_BITS-1:0] m_echo_id_reg;
    logic               m_is_match_reg;
    logic               m_nearest_found_reg;
    logic [ID_BITS-1:0] m_nearest_id_reg;
    logic               m_query_done_reg;

    logic [D_W-1:0]     xz_sum;
    logic [D_W-1:0]     d3_sum;
    logic [D_W-1:0]     kept_d;
    logic               match;
    logic               take;
    logic               found;
    logic [ID_BITS-1:0] found_id;

    // Pipeline flow: stall everything behind a held result
    assign out_free = !m_valid_reg || m_ready;
    assign in_ready = !s1_valid_reg || out_free;
    assign s1_adv   = s1_valid_reg && out_free;

    // Square stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (in_ready) begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            s1_id_reg    <= in_id;
            s1_sqx_reg   <= sat_square(magnitude(in_diff_x));
            s1_sqy_reg   <= sat_square(magnitude(in_diff_y));
            s1_sqz_reg   <= sat_square(magnitude(in_diff_z));
            s1_flags_reg <= in_flags;
        end
    end

    // Radius test and compare against the kept nearest distance
    always_comb begin
        xz_sum   = D_W'(s1_sqx_reg) + D_W'(s1_sqz_reg);
        d3_sum   = xz_sum + D_W'(s1_sqy_reg);
        kept_d   = best_valid_reg ? best_d_reg : D_W'(radius_sq);
        match    = s1_flags_reg.cand_ok && (xz_sum < D_W'(radius_sq));
        take     = match && (kept_d >= d3_sum);
        found    = take || best_valid_reg;
        found_id = take ? s1_id_reg : (best_valid_reg ? best_id_reg : '0);

        best_d_next     = best_d_reg;
        best_id_next    = best_id_reg;
        best_valid_next = best_valid_reg;
        if (s1_adv) begin
            if (s1_flags_reg.last) begin
                best_d_next     = '0;
                best_id_next    = '0;
                best_valid_next = 1'b0;
            end else if (take) begin
                best_d_next     = d3_sum;
                best_id_next    = s1_id_reg;
                best_valid_next = 1'b1;
            end
        end
    end

    // Nearest search state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            best_d_reg     <= '0;
            best_id_reg    <= '0;
            best_valid_reg <= 1'b0;
        end else begin
            best_d_reg     <= best_d_next;
            best_id_reg    <= best_id_next;
            best_valid_reg <= best_valid_next;
        end
    end

    // Result register: load on advance, drop on accept
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s1_adv) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_adv) begin
            m_echo_id_reg       <= s1_id_reg;
            m_is_match_reg      <= match;
            m_nearest_found_reg <= s1_flags_reg.last && found;
            m_nearest_id_reg    <= s1_flags_reg.last ? found_id : '0;
            m_query_done_reg    <= s1_flags_reg.last;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_echo_id       = m_echo_id_reg;
    assign m_is_match      = m_is_match_reg;
    assign m_nearest_found = m_nearest_found_reg;
    assign m_nearest_id    = m_nearest_id_reg;
    assign m_query_done    = m_query_done_reg;

`ifndef ASSERT_OFF
    a_clear_after_last: assert property (@(posedge aclk) disable iff (!aresetn)
        s1_adv && s1_flags_reg.last |=> !best_valid_reg)
        else $error("search state not cleared after last candidate");

    a_nearest_only_on_done: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && !m_query_done_reg |-> !m_nearest_found_reg && m_nearest_id_reg == '0)
        else $error("nearest result shown on a candidate that is not last");

    a_reject_no_match: assert property (@(posedge aclk) disable iff (!aresetn)
        s1_adv && !s1_flags_reg.cand_ok |=> !m_is_match_reg)
        else $error("filtered candidate reported as match");

    a_kept_valid_found: assert property (@(posedge aclk) disable iff (!aresetn)
        s1_adv && s1_flags_reg.last && best_valid_reg |=> m_nearest_found_reg)
        else $error("kept nearest candidate lost at end of query");
`endif

endmodule

// ===== src/cylinder_nearest_query.sv =====
// Top level of the cylinder nearest-object query block.
// Depends on cnq_pkg, cnq_cfg, cnq_front, cnq_fifo and cnq_back.
//
// Streams candidate objects and returns one result beat per candidate: its id, whether it
// lies inside the vertical cylinder and passes the hitbox, self and class filters, and on
// the candidate marked last the id of the nearest match (squared 3D distance from the
// origin, later match wins a tie) with a found flag. The block sustains one candidate per
// clock unless the output stalls; that rate is set by the compare and registered update of
// the kept nearest distance in the back end. A candidate's result passes the queue, the
// square stage and the result register; a four-entry queue decouples the classifying front
// end from the distance back end. Configuration writes take effect on the cycle after the
// write for the register itself and in the cycle after that for the derived band limits
// and radius square; write configuration only while no candidate is in flight.
module cylinder_nearest_query #(
    parameter int ID_BITS    = 10,
    parameter int COORD_BITS = 24,
    parameter int CLASS_BITS = 4
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // configuration write port
    input  logic                              cfg_we,
    input  logic [cnq_pkg::CFG_IDX_BITS-1:0]  cfg_idx,
    input  logic [COORD_BITS-1:0]             cfg_wdata,
    // candidate channel
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [ID_BITS-1:0]                s_entry_id,
    input  logic signed [COORD_BITS-1:0]      s_obj_x,
    input  logic signed [COORD_BITS-1:0]      s_obj_y,
    input  logic signed [COORD_BITS-1:0]      s_obj_z,
    input  logic signed [COORD_BITS-1:0]      s_off_x,
    input  logic signed [COORD_BITS-1:0]      s_off_y,
    input  logic signed [COORD_BITS-1:0]      s_off_z,
    input  logic                              s_has_hitbox,
    input  logic                              s_is_self,
    input  logic [CLASS_BITS-1:0]             s_object_class,
    input  logic                              s_last_entry,
    // result channel
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [ID_BITS-1:0]                m_echo_id,
    output logic                              m_is_match,
    output logic                              m_nearest_found,
    output logic [ID_BITS-1:0]                m_nearest_id,
    output logic                              m_query_done
);
    import cnq_pkg::*;

    localparam int C      = COORD_BITS;
    localparam int FLAG_W = $bits(cnq_flags_t);
    localparam int Q_W    = ID_BITS + 3 * (C + 2) + FLAG_W;

    logic signed [C-1:0]   origin_x;
    logic signed [C-1:0]   origin_y;
    logic signed [C-1:0]   origin_z;
    logic [CLASS_BITS-1:0] wanted_class;
    logic signed [C:0]     band_lo;
    logic signed [C:0]     band_hi;
    logic [2*C-3:0]        radius_sq;

    logic signed [C+1:0]   f_diff_x;
    logic signed [C+1:0]   f_diff_y;
    logic signed [C+1:0]   f_diff_z;
    cnq_flags_t            f_flags;

    logic                  q_full;
    logic                  q_push;
    logic                  q_pop;
    logic                  q_not_empty;
    logic [Q_W-1:0]        q_wr_data;
    logic [Q_W-1:0]        q_rd_data;

    logic [ID_BITS-1:0]    b_id;
    logic signed [C+1:0]   b_diff_x;
    logic signed [C+1:0]   b_diff_y;
    logic signed [C+1:0]   b_diff_z;
    cnq_flags_t            b_flags;

    cnq_cfg #(
        .COORD_BITS (COORD_BITS),
        .CLASS_BITS (CLASS_BITS)
    ) u_cfg (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_we       (cfg_we),
        .cfg_idx      (cfg_idx),
        .cfg_wdata    (cfg_wdata),
        .origin_x     (origin_x),
        .origin_y     (origin_y),
        .origin_z     (origin_z),
        .wanted_class (wanted_class),
        .band_lo      (band_lo),
        .band_hi      (band_hi),
        .radius_sq    (radius_sq)
    );

    cnq_front #(
        .COORD_BITS (COORD_BITS),
        .CLASS_BITS (CLASS_BITS)
    ) u_front (
        .obj_x        (s_obj_x),
        .obj_y        (s_obj_y),
        .obj_z        (s_obj_z),
        .off_x        (s_off_x),
        .off_y        (s_off_y),
        .off_z        (s_off_z),
        .has_hitbox   (s_has_hitbox),
        .is_self      (s_is_self),
        .object_class (s_object_class),
        .last_entry   (s_last_entry),
        .origin_x     (origin_x),
        .origin_y     (origin_y),
        .origin_z     (origin_z),
        .wanted_class (wanted_class),
        .band_lo      (band_lo),
        .band_hi      (band_hi),
        .diff_x       (f_diff_x),
        .diff_y       (f_diff_y),
        .diff_z       (f_diff_z),
        .flags        (f_flags)
    );

    // Accept a candidate whenever the queue has room
    assign s_ready   = !q_full;
    assign q_push    = s_valid && s_ready;
    assign q_wr_data = {s_entry_id, f_diff_x, f_diff_y, f_diff_z, f_flags};

    cnq_fifo #(
        .WIDTH (Q_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .wr_en     (q_push),
        .wr_data   (q_wr_data),
        .full      (q_full),
        .rd_en     (q_pop),
        .rd_data   (q_rd_data),
        .not_empty (q_not_empty)
    );

    assign {b_id, b_diff_x, b_diff_y, b_diff_z, b_flags} = q_rd_data;

    logic b_ready;
    assign q_pop = q_not_empty && b_ready;

    cnq_back #(
        .ID_BITS    (ID_BITS),
        .COORD_BITS (COORD_BITS)
    ) u_back (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .in_valid        (q_not_empty),
        .in_ready        (b_ready),
        .in_id           (b_id),
        .in_diff_x       (b_diff_x),
        .in_diff_y       (b_diff_y),
        .in_diff_z       (b_diff_z),
        .in_flags        (b_flags),
        .radius_sq       (radius_sq),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_echo_id       (m_echo_id),
        .m_is_match      (m_is_match),
        .m_nearest_found (m_nearest_found),
        .m_nearest_id    (m_nearest_id),
        .m_query_done    (m_query_done)
    );

endmodule
